>>> src/lpht_pkg.sv
package lpht_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UPDATED   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_COMMIT
    } fsm_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

>>> src/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/lpht_hash.sv
// Key trim and home-slot hash, one key byte per cycle.
module lpht_hash #(
    parameter int TABLE_SLOTS = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lpht_pkg::KEY_W-1:0]     key_in,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home,
    output logic [8*KEY_BYTES-1:0]         key_norm
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int LW = $clog2(KEY_BYTES + 1);
    localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [IW:0] SLOTS_V = (IW+1)'(TABLE_SLOTS);

    // h*128 + b mod N, folded in bit by bit: each step stays below 2N
    function automatic logic [IW-1:0] hash_step(input logic [IW-1:0] h, input logic [7:0] b);
        logic [IW:0] t;
        t = {1'b0, h} + (IW+1)'(b[7]);
        if (t >= SLOTS_V)
        begin
            t = t - SLOTS_V;
        end
        for (int i = 6; i >= 0; i--)
        begin
            t = {t[IW-1:0], b[i]};
            if (t >= SLOTS_V)
            begin
                t = t - SLOTS_V;
            end
        end
        return t[IW-1:0];
    endfunction

    logic [KEY_BYTES-1:0][7:0] trim_key;
    logic [LW-1:0]             trim_len;

    logic [KEY_BYTES-1:0][7:0] key_reg;
    logic [LW-1:0]             len_reg;
    logic [LW-1:0]             cnt_reg;
    logic [IW-1:0]             h_reg;
    logic                      run_reg;
    logic                      done_reg;

    always_comb
    begin
        logic alive;
        alive    = 1'b1;
        trim_key = '0;
        trim_len = '0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            alive = alive && (key_in[8*i +: 8] != 8'd0);
            if (alive)
            begin
                trim_key[i] = key_in[8*i +: 8];
                trim_len    = LW'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && (cnt_reg == len_reg))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= trim_key;
            len_reg <= trim_len;
            cnt_reg <= '0;
            h_reg   <= '0;
        end
        else if (run_reg && (cnt_reg != len_reg))
        begin
            h_reg   <= hash_step(h_reg, key_reg[cnt_reg[BW-1:0]]);
            cnt_reg <= cnt_reg + LW'(1);
        end
    end

    assign done     = done_reg;
    assign home     = h_reg;
    assign key_norm = key_reg;

endmodule

>>> src/linear_probe_hash_table_core.sv
// Channel   Handshake         Payload
// request   start / busy      request (op, key, value)
// result    done (strobe)     result (status, value_out, entry_count)
//
// After reset the slot memory is cleared, one slot a cycle, with busy high.
// An item's trimmed key is hashed byte by byte, then slots are probed from its home slot
// (one memory read per cycle, up to TABLE_SLOTS on a miss) before the result is committed.
// Op 3 and an insert into a full table answer in the cycle after accept, without probing.
// done is registered; the next request may be taken in the cycle done is shown.
module linear_probe_hash_table_core #(
    parameter int TABLE_SLOTS = 64,
    parameter int KEY_BYTES   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lpht_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output lpht_pkg::rsp_t result
);

    localparam int IW       = $clog2(TABLE_SLOTS);
    localparam int CW       = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_BITS = 8 * KEY_BYTES;
    localparam int EW       = 1 + KEY_BITS + lpht_pkg::VALUE_W;
    localparam logic [CW-1:0] SLOTS_C  = CW'(TABLE_SLOTS);
    localparam logic [CW-1:0] LAST_CHK = CW'(TABLE_SLOTS - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    lpht_pkg::fsm_t state_reg, state_next;
    lpht_pkg::op_t  op_reg, op_next;
    logic [lpht_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] probe_idx_reg, probe_idx_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic [CW-1:0] checked_reg, checked_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic          free_vld_reg, free_vld_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [lpht_pkg::VALUE_W-1:0] hit_val_reg, hit_val_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic          done_reg, done_next;
    lpht_pkg::rsp_t rsp_reg, rsp_next;

    logic                accept;
    logic                full;
    logic                issue_ok;
    logic                hash_start;
    logic                hash_done;
    logic [IW-1:0]       home;
    logic [KEY_BITS-1:0] key_norm;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;
    logic                rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [lpht_pkg::VALUE_W-1:0] rd_val;

    assign busy     = (state_reg != lpht_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign full     = (count_reg == SLOTS_C);
    assign issue_ok = (issued_reg != SLOTS_C);
    assign rd_valid = ram_rdata[EW-1];
    assign rd_key   = ram_rdata[lpht_pkg::VALUE_W +: KEY_BITS];
    assign rd_val   = ram_rdata[lpht_pkg::VALUE_W-1:0];
    assign done     = done_reg;
    assign result   = rsp_reg;

    lpht_hash #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (hash_start),
        .key_in   (request.key),
        .done     (hash_done),
        .home     (home),
        .key_norm (key_norm)
    );

    // slot entry: {valid, key, value}
    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lpht_pkg::S_CLEAR;
            count_reg   <= '0;
            clr_idx_reg <= '0;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_idx_reg <= clr_idx_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        probe_idx_reg <= probe_idx_next;
        issued_reg    <= issued_next;
        checked_reg   <= checked_next;
        chk_idx_reg   <= chk_idx_next;
        free_vld_reg  <= free_vld_next;
        free_idx_reg  <= free_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_val_reg   <= hit_val_next;
        rsp_reg       <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        probe_idx_next = probe_idx_reg;
        issued_next    = issued_reg;
        checked_next   = checked_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        free_vld_next  = free_vld_reg;
        free_idx_next  = free_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_val_next   = hit_val_reg;
        clr_idx_next   = clr_idx_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        hash_start     = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_idx_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = probe_idx_reg;

        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end

            lpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = request.op;
                    val_next = request.value;
                    if (request.op == lpht_pkg::OP_NOP ||
                        (request.op == lpht_pkg::OP_INSERT && full))
                    begin
                        done_next            = 1'b1;
                        rsp_next.status      = (request.op == lpht_pkg::OP_NOP) ?
                                               lpht_pkg::STAT_NOT_FOUND : lpht_pkg::STAT_FULL;
                        rsp_next.value_out   = '0;
                        rsp_next.entry_count = lpht_pkg::COUNT_W'(count_reg);
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = lpht_pkg::S_HASH;
                    end
                end
            end

            lpht_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    state_next     = lpht_pkg::S_PROBE;
                    probe_idx_next = home;
                    issued_next    = '0;
                    checked_next   = '0;
                    chk_vld_next   = 1'b0;
                    free_vld_next  = 1'b0;
                    hit_next       = 1'b0;
                end
            end

            lpht_pkg::S_PROBE:
            begin
                // reads run one slot ahead of the compare
                ram_re       = issue_ok;
                chk_vld_next = issue_ok;
                chk_idx_next = probe_idx_reg;
                if (issue_ok)
                begin
                    probe_idx_next = (probe_idx_reg == LAST_IDX) ? '0 : probe_idx_reg + IW'(1);
                    issued_next    = issued_reg + CW'(1);
                end
                if (chk_vld_reg)
                begin
                    if (rd_valid && (rd_key == key_norm))
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = chk_idx_reg;
                        hit_val_next = rd_val;
                        chk_vld_next = 1'b0;
                        state_next   = lpht_pkg::S_COMMIT;
                    end
                    else
                    begin
                        if (!rd_valid && !free_vld_reg)
                        begin
                            free_vld_next = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                        checked_next = checked_reg + CW'(1);
                        if (checked_reg == LAST_CHK)
                        begin
                            chk_vld_next = 1'b0;
                            state_next   = lpht_pkg::S_COMMIT;
                        end
                    end
                end
            end

            lpht_pkg::S_COMMIT:
            begin
                state_next         = lpht_pkg::S_IDLE;
                done_next          = 1'b1;
                rsp_next.status    = lpht_pkg::STAT_NOT_FOUND;
                rsp_next.value_out = '0;
                case (op_reg)
                    lpht_pkg::OP_INSERT:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, key_norm, val_reg};
                        if (hit_reg)
                        begin
                            ram_waddr       = hit_idx_reg;
                            rsp_next.status = lpht_pkg::STAT_UPDATED;
                        end
                        else
                        begin
                            // not full, so the scan saw a free slot
                            ram_waddr       = free_idx_reg;
                            count_next      = count_reg + CW'(1);
                            rsp_next.status = lpht_pkg::STAT_OK;
                        end
                    end
                    lpht_pkg::OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.status    = lpht_pkg::STAT_OK;
                            rsp_next.value_out = hit_val_reg;
                        end
                    end
                    lpht_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = hit_idx_reg;
                            count_next         = count_reg - CW'(1);
                            rsp_next.status    = lpht_pkg::STAT_OK;
                            rsp_next.value_out = hit_val_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.entry_count = lpht_pkg::COUNT_W'(count_next);
            end

            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/lpht_checker.sv
module lpht_checker #(
    parameter int TABLE_SLOTS = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input lpht_pkg::rsp_t result
);

    // every result answers a request taken earlier
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result without a pending request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.entry_count) <= TABLE_SLOTS))
        else $error("entry count beyond table size");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == lpht_pkg::STAT_FULL) |->
            (result.entry_count == lpht_pkg::COUNT_W'(TABLE_SLOTS)))
        else $error("full status with free slots");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == lpht_pkg::STAT_NOT_FOUND ||
                  result.status == lpht_pkg::STAT_FULL ||
                  result.status == lpht_pkg::STAT_UPDATED)) |->
            (result.value_out == '0))
        else $error("value returned without a hit");

endmodule

bind linear_probe_hash_table_core lpht_checker #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_lpht_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
